/* rtl/core/rbei_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbei_pkg
// Shared types and constants of the rigid body Euler integration core.
// ----------------------------------------------------------------------------
package rbei_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DT_W          = 17;
   localparam logic [DT_W-1:0] TIME_STEP_RESET = 17'd1092;

   localparam int ROOT_W = 32;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int QUO_W  = 32;
   localparam int DIVD_W = QUO_W + 31;

   localparam int MID_DEPTH_DEF = 4;
   localparam int OUT_DEPTH_DEF = 2;

   typedef enum logic [1:0] {
      KIND_DYNAMIC = 2'b01,
      KIND_STATIC  = 2'b10
   } body_kind_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic [30:0]        recip_mass;
      logic [30:0]        friction;
      logic [30:0]        half_width;
      logic [30:0]        half_height;
      logic               static_flag;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] box_min_x;
      logic signed [31:0] box_min_y;
      logic signed [31:0] box_max_x;
      logic signed [31:0] box_max_y;
      logic               integrated;
   } rsp_type;

   typedef struct packed {
      req_type          body;
      logic [DT_W-1:0]  dt;
      body_kind_type    kind;
   } job_type;

   // Sideband that rides along the square root and divide pipelines
   typedef struct packed {
      body_kind_type      kind;
      logic               limit;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] old_vel_x;
      logic signed [31:0] old_vel_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic [30:0]        half_width;
      logic [30:0]        half_height;
      logic [DT_W-1:0]    dt;
   } carry_type;

endpackage
`default_nettype wire

/* rtl/core/rigid_body_euler_integrate_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rigid_body_euler_integrate_core
// One semi-implicit Euler step per 2D rigid body, with speed limit and box.
// ----------------------------------------------------------------------------
// The core takes one body per cycle while req_full is low and returns one
// result per body, in order, via a request register, the job queue, eight
// arithmetic stages, a 32-stage square root pipeline, a scaling stage, a
// 32-stage divider pipeline and four stages for position and box. Both the
// root and the divide are fully pipelined, so the sustained rate is one
// body per cycle whenever the result side pops. When the result queue is
// full the whole back pipeline holds and the job queue absorbs new requests
// until it too is full. The time step register may be written only while
// the core is empty; the step is captured with each request.
// ----------------------------------------------------------------------------
module rigid_body_euler_integrate_core #(
   parameter int FRAC_BITS = rbei_pkg::FRAC_BITS_DEF,
   parameter int MID_DEPTH = rbei_pkg::MID_DEPTH_DEF,
   parameter int OUT_DEPTH = rbei_pkg::OUT_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  rbei_pkg::req_type          req_data,
   output logic                       req_full,
   input  logic                       rsp_pop,
   output rbei_pkg::rsp_type          rsp_data,
   output logic                       rsp_empty,
   input  logic                       csr_we,
   input  logic [rbei_pkg::DT_W-1:0]  csr_wdata
);
   import rbei_pkg::*;

   localparam int JOB_W = $bits(job_type);
   localparam int RSP_W = $bits(rsp_type);

   logic             job_push, job_full, job_pop, job_empty;
   job_type          front_job, back_job;
   logic [JOB_W-1:0] back_job_bits;
   logic             rsp_push, rsp_full;
   rsp_type          back_rsp;
   logic [RSP_W-1:0] rsp_bits;

   assign back_job = job_type'(back_job_bits);
   assign rsp_data = rsp_type'(rsp_bits);

   rbei_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .job_push  (job_push),
      .job_data  (front_job),
      .job_full  (job_full)
   );

   rbei_fifo #(.WIDTH(JOB_W), .DEPTH(MID_DEPTH)) u_job_q (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (JOB_W'(front_job)),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (back_job_bits),
      .empty     (job_empty)
   );

   rbei_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_data  (back_job),
      .job_pop   (job_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (back_rsp)
   );

   rbei_fifo #(.WIDTH(RSP_W), .DEPTH(OUT_DEPTH)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (RSP_W'(back_rsp)),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .empty     (rsp_empty)
   );

endmodule
`default_nettype wire

/* rtl/core/rbei_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbei_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module rbei_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/rbei_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbei_front
// Accepts requests, holds the time step register, clamps the step to one
// and tags each body as static or dynamic before it enters the job queue.
// ----------------------------------------------------------------------------
module rbei_front #(
   parameter int FRAC_BITS = rbei_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   input  rbei_pkg::req_type            req_data,
   output logic                         req_full,
   input  logic                         csr_we,
   input  logic [rbei_pkg::DT_W-1:0]    csr_wdata,
   output logic                         job_push,
   output rbei_pkg::job_type            job_data,
   input  logic                         job_full
);
   import rbei_pkg::*;

   localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

   logic [DT_W-1:0] time_step_ff, time_step_in;
   logic            valid_ff, valid_in;
   job_type         job_ff, job_in;
   logic            accept;

   assign req_full = valid_ff && job_full;
   assign accept   = req_push && !req_full;
   assign job_push = valid_ff && !job_full;
   assign job_data = job_ff;

   always_comb begin
      time_step_in = csr_we ? csr_wdata : time_step_ff;
      valid_in     = accept || (valid_ff && job_full);
      job_in       = job_ff;
      if (accept) begin
         job_in.body = req_data;
         job_in.dt   = (32'(time_step_ff) > ONE) ? DT_W'(ONE) : time_step_ff;
         job_in.kind = req_data.static_flag ? KIND_STATIC : KIND_DYNAMIC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= TIME_STEP_RESET;
         valid_ff     <= 1'b0;
      end else begin
         time_step_ff <= time_step_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

endmodule
`default_nettype wire

/* rtl/core/rbei_sqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbei_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rbei_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  rbei_pkg::carry_type           in_carry,
   input  logic [rbei_pkg::RAD_W-1:0]    in_rad,
   output logic                          out_valid,
   output rbei_pkg::carry_type           out_carry,
   output logic [rbei_pkg::ROOT_W-1:0]   out_root
);
   import rbei_pkg::*;

   localparam int REM_W = ROOT_W + 4;

   logic             valid_ff [ROOT_W];
   logic             valid_in [ROOT_W];
   carry_type        carry_ff [ROOT_W];
   carry_type        carry_in [ROOT_W];
   logic [RAD_W-1:0] rad_ff   [ROOT_W];
   logic [RAD_W-1:0] rad_in   [ROOT_W];
   logic [REM_W-1:0] rem_ff   [ROOT_W];
   logic [REM_W-1:0] rem_in   [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];

   always_comb begin
      for (int k = 0; k < ROOT_W; k++) begin
         logic [REM_W-1:0]  rem_p, r2, trial;
         logic [ROOT_W-1:0] root_p;
         logic [RAD_W-1:0]  rad_p;
         logic              ge;
         if (k == 0) begin
            valid_in[k] = in_valid;
            carry_in[k] = in_carry;
            rem_p       = '0;
            root_p      = '0;
            rad_p       = in_rad;
         end else begin
            valid_in[k] = valid_ff[k-1];
            carry_in[k] = carry_ff[k-1];
            rem_p       = rem_ff[k-1];
            root_p      = root_ff[k-1];
            rad_p       = rad_ff[k-1];
         end
         // bring down the next two radicand bits and try root*4+1
         r2         = {rem_p[REM_W-3:0], rad_p[RAD_W-1 -: 2]};
         trial      = {2'b00, root_p, 2'b01};
         ge         = (r2 >= trial);
         rem_in[k]  = ge ? (r2 - trial) : r2;
         root_in[k] = {root_p[ROOT_W-2:0], ge};
         rad_in[k]  = {rad_p[RAD_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ROOT_W; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         for (int k = 0; k < ROOT_W; k++) begin
            valid_ff[k] <= valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < ROOT_W; k++) begin
            carry_ff[k] <= carry_in[k];
            rad_ff[k]   <= rad_in[k];
            rem_ff[k]   <= rem_in[k];
            root_ff[k]  <= root_in[k];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_carry = carry_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];

endmodule
`default_nettype wire

/* rtl/core/rbei_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbei_div
// Two-lane pipelined restoring divider sharing one divisor, one quotient
// bit per stage. The upper dividend bits must stay below the divisor.
// ----------------------------------------------------------------------------
module rbei_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  rbei_pkg::carry_type           in_carry,
   input  logic [rbei_pkg::DIVD_W-1:0]   in_num_x,
   input  logic [rbei_pkg::DIVD_W-1:0]   in_num_y,
   input  logic [rbei_pkg::QUO_W-1:0]    in_den,
   output logic                          out_valid,
   output rbei_pkg::carry_type           out_carry,
   output logic [rbei_pkg::QUO_W-1:0]    out_quo_x,
   output logic [rbei_pkg::QUO_W-1:0]    out_quo_y
);
   import rbei_pkg::*;

   logic             valid_ff [QUO_W];
   logic             valid_in [QUO_W];
   carry_type        carry_ff [QUO_W];
   carry_type        carry_in [QUO_W];
   logic [QUO_W-1:0] den_ff   [QUO_W];
   logic [QUO_W-1:0] den_in   [QUO_W];
   logic [QUO_W-1:0] rem_x_ff [QUO_W];
   logic [QUO_W-1:0] rem_x_in [QUO_W];
   logic [QUO_W-1:0] lo_x_ff  [QUO_W];
   logic [QUO_W-1:0] lo_x_in  [QUO_W];
   logic [QUO_W-1:0] rem_y_ff [QUO_W];
   logic [QUO_W-1:0] rem_y_in [QUO_W];
   logic [QUO_W-1:0] lo_y_ff  [QUO_W];
   logic [QUO_W-1:0] lo_y_in  [QUO_W];

   always_comb begin
      for (int k = 0; k < QUO_W; k++) begin
         logic [QUO_W-1:0] den_p, rx_p, lx_p, ry_p, ly_p;
         logic [QUO_W:0]   tx, ty;
         logic             gx, gy;
         if (k == 0) begin
            valid_in[k] = in_valid;
            carry_in[k] = in_carry;
            den_p       = in_den;
            rx_p        = QUO_W'(in_num_x[DIVD_W-1:QUO_W]);
            lx_p        = in_num_x[QUO_W-1:0];
            ry_p        = QUO_W'(in_num_y[DIVD_W-1:QUO_W]);
            ly_p        = in_num_y[QUO_W-1:0];
         end else begin
            valid_in[k] = valid_ff[k-1];
            carry_in[k] = carry_ff[k-1];
            den_p       = den_ff[k-1];
            rx_p        = rem_x_ff[k-1];
            lx_p        = lo_x_ff[k-1];
            ry_p        = rem_y_ff[k-1];
            ly_p        = lo_y_ff[k-1];
         end
         // shift in the next dividend bit, quotient bits fill the low end
         tx          = {rx_p, lx_p[QUO_W-1]};
         ty          = {ry_p, ly_p[QUO_W-1]};
         gx          = (tx >= {1'b0, den_p});
         gy          = (ty >= {1'b0, den_p});
         rem_x_in[k] = gx ? QUO_W'(tx - {1'b0, den_p}) : QUO_W'(tx);
         rem_y_in[k] = gy ? QUO_W'(ty - {1'b0, den_p}) : QUO_W'(ty);
         lo_x_in[k]  = {lx_p[QUO_W-2:0], gx};
         lo_y_in[k]  = {ly_p[QUO_W-2:0], gy};
         den_in[k]   = den_p;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QUO_W; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         for (int k = 0; k < QUO_W; k++) begin
            valid_ff[k] <= valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QUO_W; k++) begin
            carry_ff[k] <= carry_in[k];
            den_ff[k]   <= den_in[k];
            rem_x_ff[k] <= rem_x_in[k];
            lo_x_ff[k]  <= lo_x_in[k];
            rem_y_ff[k] <= rem_y_in[k];
            lo_y_ff[k]  <= lo_y_in[k];
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_carry = carry_ff[QUO_W-1];
   assign out_quo_x = lo_x_ff[QUO_W-1];
   assign out_quo_y = lo_y_ff[QUO_W-1];

endmodule
`default_nettype wire

/* rtl/core/rbei_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbei_back
// Integration pipeline: acceleration, velocity, damping, speed limit,
// position and bounding box. The whole pipeline holds when the result
// queue is full and the last stage holds a result.
// ----------------------------------------------------------------------------
module rbei_back #(
   parameter int FRAC_BITS = rbei_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_empty,
   input  rbei_pkg::job_type  job_data,
   output logic               job_pop,
   input  logic               rsp_full,
   output logic               rsp_push,
   output rbei_pkg::rsp_type  rsp_data
);
   import rbei_pkg::*;

   localparam int KEEP_W = FRAC_BITS + 1;
   localparam int PF_W   = 63;
   localparam int PR_W   = 31 + DT_W;
   localparam int PA_W   = 32 + DT_W + 1;
   localparam int PD_W   = 32 + KEEP_W + 1;
   localparam logic signed [63:0] ONE64   = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] GRAV    =
      64'(((64'd981 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [31:0]        MAXV    = 32'(100) << FRAC_BITS;
   localparam logic [63:0]        MAXV_SQ = 64'(10000) << (2 * FRAC_BITS);

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (x < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return 32'(x);
   endfunction

   logic en;

   // stage 1..8 valids
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic v9_ff, v10_ff, v11_ff, v12_ff, v13_ff;

   job_type                 j1_ff, j2_ff, j3_ff, j4_ff, j5_ff, j6_ff, j7_ff;
   logic signed [PF_W-1:0]  pfx1_ff, pfy1_ff, pfx1_in, pfy1_in;
   logic [PR_W-1:0]         pfr1_ff, pfr1_in;
   logic signed [31:0]      ax2_ff, ay2_ff, ax2_in, ay2_in;
   logic [KEEP_W-1:0]       keep2_ff, keep3_ff, keep4_ff, keep2_in;
   logic signed [PA_W-1:0]  pax3_ff, pay3_ff, pax3_in, pay3_in;
   logic signed [31:0]      vx4_ff, vy4_ff, vx4_in, vy4_in;
   logic signed [PD_W-1:0]  pdx5_ff, pdy5_ff, pdx5_in, pdy5_in;
   logic signed [31:0]      vx6_ff, vy6_ff, vx6_in, vy6_in;
   logic signed [31:0]      vx7_ff, vy7_ff;
   logic signed [63:0]      sqx7_ff, sqy7_ff, sqx7_in, sqy7_in;
   carry_type               c8_ff, c8_in;
   logic [63:0]             lsq8_ff, lsq8_in;

   logic                    vs;
   carry_type               cs;
   logic [ROOT_W-1:0]       root_s;

   carry_type               c9_ff, c9_in;
   logic [DIVD_W-1:0]       mdx9_ff, mdy9_ff, mdx9_in, mdy9_in;
   logic [QUO_W-1:0]        len9_ff;

   logic                    vd;
   carry_type               cd;
   logic [QUO_W-1:0]        qx_d, qy_d;

   carry_type               c10_ff, c11_ff, c12_ff;
   logic signed [31:0]      vfx10_ff, vfy10_ff, vfx10_in, vfy10_in;
   logic signed [31:0]      vfx11_ff, vfy11_ff, vfx12_ff, vfy12_ff;
   logic signed [PA_W-1:0]  ppx11_ff, ppy11_ff, ppx11_in, ppy11_in;
   logic signed [31:0]      px12_ff, py12_ff, px12_in, py12_in;
   rsp_type                 rsp13_ff, rsp13_in;

   assign en       = !v13_ff || !rsp_full;
   assign job_pop  = en && !job_empty;
   assign rsp_push = v13_ff && !rsp_full;
   assign rsp_data = rsp13_ff;

   always_comb begin
      logic [63:0]      fd;
      logic [63:0]      lsq;
      logic [31:0]      magx, magy;
      logic [QUO_W-1:0] qxc, qyc;
      logic signed [63:0] bminx, bminy, bmaxx, bmaxy;

      // force times inverse mass, friction times step
      pfx1_in = job_data.body.force_x * $signed({1'b0, job_data.body.recip_mass});
      pfy1_in = job_data.body.force_y * $signed({1'b0, job_data.body.recip_mass});
      pfr1_in = job_data.body.friction * job_data.dt;

      ax2_in   = sat32(64'(pfx1_ff >>> FRAC_BITS));
      ay2_in   = sat32(64'(pfy1_ff >>> FRAC_BITS) - GRAV);
      fd       = 64'(pfr1_ff >> FRAC_BITS);
      if ($signed(fd) > ONE64) begin
         fd = 64'(ONE64);
      end
      keep2_in = KEEP_W'(64'(ONE64) - fd);

      pax3_in = ax2_ff * $signed({1'b0, j2_ff.dt});
      pay3_in = ay2_ff * $signed({1'b0, j2_ff.dt});

      vx4_in = sat32(64'(j3_ff.body.vel_x) + 64'(pax3_ff >>> FRAC_BITS));
      vy4_in = sat32(64'(j3_ff.body.vel_y) + 64'(pay3_ff >>> FRAC_BITS));

      pdx5_in = vx4_ff * $signed({1'b0, keep4_ff});
      pdy5_in = vy4_ff * $signed({1'b0, keep4_ff});

      vx6_in = 32'(pdx5_ff >>> FRAC_BITS);
      vy6_in = 32'(pdy5_ff >>> FRAC_BITS);

      sqx7_in = vx6_ff * vx6_ff;
      sqy7_in = vy6_ff * vy6_ff;

      lsq               = 64'(sqx7_ff) + 64'(sqy7_ff);
      lsq8_in           = lsq;
      c8_in.kind        = j7_ff.kind;
      c8_in.limit       = (j7_ff.kind == KIND_DYNAMIC) && (lsq > MAXV_SQ);
      c8_in.pos_x       = j7_ff.body.pos_x;
      c8_in.pos_y       = j7_ff.body.pos_y;
      c8_in.old_vel_x   = j7_ff.body.vel_x;
      c8_in.old_vel_y   = j7_ff.body.vel_y;
      c8_in.vel_x       = vx7_ff;
      c8_in.vel_y       = vy7_ff;
      c8_in.half_width  = j7_ff.body.half_width;
      c8_in.half_height = j7_ff.body.half_height;
      c8_in.dt          = j7_ff.dt;

      // magnitudes scaled by the speed limit, ready for the divider
      magx    = cs.vel_x[31] ? 32'(-cs.vel_x) : 32'(cs.vel_x);
      magy    = cs.vel_y[31] ? 32'(-cs.vel_y) : 32'(cs.vel_y);
      mdx9_in = magx * MAXV[30:0];
      mdy9_in = magy * MAXV[30:0];
      c9_in   = cs;

      qxc = (qx_d > MAXV) ? MAXV : qx_d;
      qyc = (qy_d > MAXV) ? MAXV : qy_d;
      if (cd.limit) begin
         vfx10_in = cd.vel_x[31] ? -$signed(qxc) : $signed(qxc);
         vfy10_in = cd.vel_y[31] ? -$signed(qyc) : $signed(qyc);
      end else begin
         vfx10_in = cd.vel_x;
         vfy10_in = cd.vel_y;
      end

      ppx11_in = vfx10_ff * $signed({1'b0, c10_ff.dt});
      ppy11_in = vfy10_ff * $signed({1'b0, c10_ff.dt});

      px12_in = sat32(64'(c11_ff.pos_x) + 64'(ppx11_ff >>> FRAC_BITS));
      py12_in = sat32(64'(c11_ff.pos_y) + 64'(ppy11_ff >>> FRAC_BITS));

      bminx = 64'(px12_ff) - $signed(64'(c12_ff.half_width));
      bminy = 64'(py12_ff) - $signed(64'(c12_ff.half_height));
      bmaxx = 64'(px12_ff) + $signed(64'(c12_ff.half_width));
      bmaxy = 64'(py12_ff) + $signed(64'(c12_ff.half_height));
      if (c12_ff.kind == KIND_STATIC) begin
         rsp13_in.new_pos_x  = c12_ff.pos_x;
         rsp13_in.new_pos_y  = c12_ff.pos_y;
         rsp13_in.new_vel_x  = c12_ff.old_vel_x;
         rsp13_in.new_vel_y  = c12_ff.old_vel_y;
         rsp13_in.box_min_x  = '0;
         rsp13_in.box_min_y  = '0;
         rsp13_in.box_max_x  = '0;
         rsp13_in.box_max_y  = '0;
         rsp13_in.integrated = 1'b0;
      end else begin
         rsp13_in.new_pos_x  = px12_ff;
         rsp13_in.new_pos_y  = py12_ff;
         rsp13_in.new_vel_x  = vfx12_ff;
         rsp13_in.new_vel_y  = vfy12_ff;
         rsp13_in.box_min_x  = sat32(bminx);
         rsp13_in.box_min_y  = sat32(bminy);
         rsp13_in.box_max_x  = sat32(bmaxx);
         rsp13_in.box_max_y  = sat32(bmaxy);
         rsp13_in.integrated = 1'b1;
      end
   end

   rbei_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v8_ff),
      .in_carry  (c8_ff),
      .in_rad    (lsq8_ff),
      .out_valid (vs),
      .out_carry (cs),
      .out_root  (root_s)
   );

   rbei_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v9_ff),
      .in_carry  (c9_ff),
      .in_num_x  (mdx9_ff),
      .in_num_y  (mdy9_ff),
      .in_den    (len9_ff),
      .out_valid (vd),
      .out_carry (cd),
      .out_quo_x (qx_d),
      .out_quo_y (qy_d)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
         v12_ff <= 1'b0;
         v13_ff <= 1'b0;
      end else if (en) begin
         v1_ff  <= !job_empty;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         v5_ff  <= v4_ff;
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= vs;
         v10_ff <= vd;
         v11_ff <= v10_ff;
         v12_ff <= v11_ff;
         v13_ff <= v12_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         j1_ff    <= job_data;
         pfx1_ff  <= pfx1_in;
         pfy1_ff  <= pfy1_in;
         pfr1_ff  <= pfr1_in;
         j2_ff    <= j1_ff;
         ax2_ff   <= ax2_in;
         ay2_ff   <= ay2_in;
         keep2_ff <= keep2_in;
         j3_ff    <= j2_ff;
         pax3_ff  <= pax3_in;
         pay3_ff  <= pay3_in;
         keep3_ff <= keep2_ff;
         j4_ff    <= j3_ff;
         vx4_ff   <= vx4_in;
         vy4_ff   <= vy4_in;
         keep4_ff <= keep3_ff;
         j5_ff    <= j4_ff;
         pdx5_ff  <= pdx5_in;
         pdy5_ff  <= pdy5_in;
         j6_ff    <= j5_ff;
         vx6_ff   <= vx6_in;
         vy6_ff   <= vy6_in;
         j7_ff    <= j6_ff;
         vx7_ff   <= vx6_ff;
         vy7_ff   <= vy6_ff;
         sqx7_ff  <= sqx7_in;
         sqy7_ff  <= sqy7_in;
         c8_ff    <= c8_in;
         lsq8_ff  <= lsq8_in;
         c9_ff    <= c9_in;
         mdx9_ff  <= mdx9_in;
         mdy9_ff  <= mdy9_in;
         len9_ff  <= root_s;
         c10_ff   <= cd;
         vfx10_ff <= vfx10_in;
         vfy10_ff <= vfy10_in;
         c11_ff   <= c10_ff;
         vfx11_ff <= vfx10_ff;
         vfy11_ff <= vfy10_ff;
         ppx11_ff <= ppx11_in;
         ppy11_ff <= ppy11_in;
         c12_ff   <= c11_ff;
         vfx12_ff <= vfx11_ff;
         vfy12_ff <= vfy11_ff;
         px12_ff  <= px12_in;
         py12_ff  <= py12_in;
         rsp13_ff <= rsp13_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/rbei_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbei_checker
// Port-level checks of the integration core, bound to the top level.
// ----------------------------------------------------------------------------
module rbei_checker #(
   parameter int FRAC_BITS = rbei_pkg::FRAC_BITS_DEF
) (
   input logic               clock,
   input logic               reset,
   input logic               req_full,
   input logic               rsp_pop,
   input rbei_pkg::rsp_type  rsp_data,
   input logic               rsp_empty
);
   import rbei_pkg::*;

   localparam logic signed [31:0] MAXV = 32'sd100 <<< FRAC_BITS;

   a_reset_empty : assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("core not empty after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("waiting result changed");

   a_static_box : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_data.integrated |->
         rsp_data.box_min_x == 0 && rsp_data.box_min_y == 0 &&
         rsp_data.box_max_x == 0 && rsp_data.box_max_y == 0)
      else $error("static body with nonzero box");

   a_box_order : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.integrated |->
         rsp_data.box_min_x <= rsp_data.box_max_x &&
         rsp_data.box_min_y <= rsp_data.box_max_y)
      else $error("box bounds out of order");

   a_speed_limit : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.integrated |->
         rsp_data.new_vel_x <= MAXV && rsp_data.new_vel_x >= -MAXV &&
         rsp_data.new_vel_y <= MAXV && rsp_data.new_vel_y >= -MAXV)
      else $error("velocity above speed limit");

endmodule

bind rigid_body_euler_integrate_core rbei_checker #(.FRAC_BITS(FRAC_BITS)) u_rbei_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data),
   .rsp_empty (rsp_empty)
);
`default_nettype wire
